// ===== rtl/gac_pkg.sv =====
package gac_pkg;

  // Default frame store geometry
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int FRAME_DIM_W = 9;   // width of the frame size registers
  localparam int CFG_IDX_W   = 2;
  localparam int POS_W       = 12;
  localparam int CMP_W       = 14;  // covers 12-bit positions and sizes up to 4096
  localparam int PIX_W       = 32;

  localparam logic [7:0] BYTE_MAX = 8'hff;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Item function codes
  localparam logic FUNC_BLEND = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              func;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]        coverage;
    logic [7:0]        red_level;
    logic [7:0]        green_level;
    logic [7:0]        blue_level;
    logic [7:0]        transparency;
  } item_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       written;
    logic       outside;
  } result_t;

  // Stage strobes from the sequencer to the datapath
  typedef struct packed {
    logic clear;
    logic acc;
    logic rd;
    logic mul;
    logic fin;
  } ctrl_t;

  // Truncating divide by 255, exact for every value up to 255*255
  function automatic logic [8:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[16:8];
  endfunction

endpackage

// ===== rtl/gac_ifs.sv =====
interface gac_item_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic [7:0]        coverage;
  logic [7:0]        red_level;
  logic [7:0]        green_level;
  logic [7:0]        blue_level;
  logic [7:0]        transparency;

  modport source (
    output valid, func, pos_x, pos_y, coverage, red_level, green_level, blue_level,
           transparency,
    input  ready
  );
  modport sink (
    input  valid, func, pos_x, pos_y, coverage, red_level, green_level, blue_level,
           transparency,
    output ready
  );
endinterface

interface gac_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;
  logic       written;
  logic       outside;

  modport source (
    output valid, out_blue, out_green, out_red, out_alpha, written, outside,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, out_alpha, written, outside,
    output ready
  );
endinterface

interface gac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gac_pkg::CFG_IDX_W-1:0]   index;
  logic [gac_pkg::FRAME_DIM_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/gac_frame_mem.sv =====
module gac_frame_mem #(
  parameter int DEPTH = gac_pkg::MAX_WIDTH_DEF * gac_pkg::MAX_HEIGHT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [gac_pkg::PIX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [gac_pkg::PIX_W-1:0] rd_data
);

  logic [gac_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/gac_ctrl.sv =====
module gac_ctrl #(
  parameter int DEPTH = gac_pkg::MAX_WIDTH_DEF * gac_pkg::MAX_HEIGHT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  output logic            in_ready,
  output gac_pkg::ctrl_t  ctl,
  output logic [AW-1:0]   clr_addr
);

  gac_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= gac_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gac_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = gac_pkg::ST_IDLE;
      end
      gac_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gac_pkg::ST_READ;
      end
      gac_pkg::ST_READ: state_nxt = gac_pkg::ST_MUL;
      gac_pkg::ST_MUL:  state_nxt = gac_pkg::ST_FIN;
      gac_pkg::ST_FIN: begin
        if (out_free) state_nxt = gac_pkg::ST_IDLE;
      end
      default: state_nxt = gac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == gac_pkg::ST_IDLE);
    ctl.clear    = (state_r == gac_pkg::ST_CLEAR);
    ctl.acc      = in_ready && in_valid;
    ctl.rd       = (state_r == gac_pkg::ST_READ);
    ctl.mul      = (state_r == gac_pkg::ST_MUL);
    ctl.fin      = (state_r == gac_pkg::ST_FIN) && out_free;
    clr_addr     = clr_addr_r;
    clr_addr_nxt = ctl.clear ? clr_addr_r + AW'(1) : clr_addr_r;
  end

endmodule

// ===== rtl/gac_datapath.sv =====
module gac_datapath #(
  parameter int MAX_WIDTH  = gac_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gac_pkg::MAX_HEIGHT_DEF,
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                            clk,
  input  gac_pkg::ctrl_t                  ctl,
  input  gac_pkg::item_t                  item,
  input  logic [gac_pkg::FRAME_DIM_W-1:0] frame_w,
  input  logic [gac_pkg::FRAME_DIM_W-1:0] frame_h,
  output logic [AW-1:0]                   rd_addr,
  input  logic [gac_pkg::PIX_W-1:0]       rd_data,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [gac_pkg::PIX_W-1:0]       wr_data,
  output gac_pkg::result_t                result
);

  localparam int CW = gac_pkg::CMP_W;
  localparam logic [CW-1:0] W_LIM = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] H_LIM = CW'(MAX_HEIGHT);

  logic [CW-1:0] w_eff, h_eff, x_u, y_u;
  logic          outside_in;
  logic [31:0]   lin;

  logic          func_r, outside_r;
  logic [AW-1:0] addr_r;
  logic [7:0]    red_r, green_r, blue_r;
  logic [15:0]   prod_a_r;
  logic [7:0]    alpha_r;
  logic [7:0]    inv_a;
  logic [15:0]   sum_b_r, sum_g_r, sum_r_r, prod_oa_r;
  logic [7:0]    new_b, new_g, new_r, new_a;
  logic          do_write;

  // Clip against the saturated frame size
  always_comb begin
    w_eff = ({5'd0, frame_w} > W_LIM) ? W_LIM : {5'd0, frame_w};
    h_eff = ({5'd0, frame_h} > H_LIM) ? H_LIM : {5'd0, frame_h};
    x_u   = {3'd0, item.pos_x[10:0]};
    y_u   = {3'd0, item.pos_y[10:0]};
    outside_in = item.pos_x[11] || item.pos_y[11] || (x_u >= w_eff) || (y_u >= h_eff);
    lin     = 32'(y_u) * 32'(MAX_WIDTH) + 32'(x_u);
    rd_addr = lin[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      func_r    <= item.func;
      outside_r <= outside_in;
      addr_r    <= rd_addr;
      red_r     <= item.red_level;
      green_r   <= item.green_level;
      blue_r    <= item.blue_level;
      prod_a_r  <= {8'd0, item.coverage} * {8'd0, gac_pkg::BYTE_MAX - item.transparency};
    end
    if (ctl.rd) begin
      alpha_r <= 8'(gac_pkg::div255(prod_a_r));
    end
    if (ctl.mul) begin
      sum_b_r   <= {8'd0, blue_r} * {8'd0, alpha_r} + {8'd0, rd_data[7:0]} * {8'd0, inv_a};
      sum_g_r   <= {8'd0, green_r} * {8'd0, alpha_r} + {8'd0, rd_data[15:8]} * {8'd0, inv_a};
      sum_r_r   <= {8'd0, red_r} * {8'd0, alpha_r} + {8'd0, rd_data[23:16]} * {8'd0, inv_a};
      prod_oa_r <= {8'd0, rd_data[31:24]} * {8'd0, inv_a};
    end
  end

  always_comb begin
    inv_a    = gac_pkg::BYTE_MAX - alpha_r;
    new_b    = 8'(gac_pkg::div255(sum_b_r));
    new_g    = 8'(gac_pkg::div255(sum_g_r));
    new_r    = 8'(gac_pkg::div255(sum_r_r));
    new_a    = alpha_r + 8'(gac_pkg::div255(prod_oa_r));
    do_write = !outside_r && (func_r == gac_pkg::FUNC_BLEND) && (alpha_r != 8'd0);
    wr_en    = ctl.fin && do_write;
    wr_addr  = addr_r;
    wr_data  = {new_a, new_r, new_g, new_b};

    result.written = do_write;
    result.outside = outside_r;
    if (outside_r) begin
      result.out_blue  = 8'd0;
      result.out_green = 8'd0;
      result.out_red   = 8'd0;
      result.out_alpha = 8'd0;
    end else if (do_write) begin
      result.out_blue  = new_b;
      result.out_green = new_g;
      result.out_red   = new_r;
      result.out_alpha = new_a;
    end else begin
      result.out_blue  = rd_data[7:0];
      result.out_green = rd_data[15:8];
      result.out_red   = rd_data[23:16];
      result.out_alpha = rd_data[31:24];
    end
  end

endmodule

// ===== rtl/glyph_alpha_compositor.sv =====
// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------------
// in_bus    in   func, pos_x, pos_y, coverage, red/green/blue_level, transparency
// out_bus   out  out_blue, out_green, out_red, out_alpha, written, outside
// cfg_bus   in   index (0 frame_width, 1 frame_height), data
//
// An unstalled item goes through: accept and issue the frame store read,
// capture alpha, form the blend products, then divide, write back and load
// the result register, before the next item is taken.
// After reset a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT words with in_ready
// low. A stalled result holds in the output register; the next item is taken and
// waits in its last stage.
module glyph_alpha_compositor #(
  parameter int MAX_WIDTH  = gac_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gac_pkg::MAX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  gac_item_if.sink     in_bus,
  gac_result_if.source out_bus,
  gac_cfg_if.sink      cfg_bus
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [gac_pkg::FRAME_DIM_W-1:0] frame_w_r, frame_h_r;

  gac_pkg::ctrl_t   ctl;
  gac_pkg::item_t   item;
  gac_pkg::result_t result;
  gac_pkg::result_t res_r;
  logic             out_valid_r;
  logic             out_free;

  logic [AW-1:0]             clr_addr, rd_addr, dp_wr_addr, mem_wr_addr;
  logic [gac_pkg::PIX_W-1:0] rd_data, dp_wr_data, mem_wr_data;
  logic                      dp_wr_en, mem_wr_en;

  // Configuration: always ready, unknown indexes dropped
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= 9'd256;
      frame_h_r <= 9'd256;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        gac_pkg::REG_FRAME_WIDTH:  frame_w_r <= cfg_bus.data;
        gac_pkg::REG_FRAME_HEIGHT: frame_h_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign item = '{
    func:         in_bus.func,
    pos_x:        in_bus.pos_x,
    pos_y:        in_bus.pos_y,
    coverage:     in_bus.coverage,
    red_level:    in_bus.red_level,
    green_level:  in_bus.green_level,
    blue_level:   in_bus.blue_level,
    transparency: in_bus.transparency
  };

  assign out_free = !out_valid_r || out_bus.ready;

  gac_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .out_free (out_free),
    .in_ready (in_bus.ready),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  gac_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk     (clk),
    .ctl     (ctl),
    .item    (item),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (dp_wr_en),
    .wr_addr (dp_wr_addr),
    .wr_data (dp_wr_data),
    .result  (result)
  );

  // Clearing pass owns the write port until it finishes
  assign mem_wr_en   = ctl.clear || dp_wr_en;
  assign mem_wr_addr = ctl.clear ? clr_addr : dp_wr_addr;
  assign mem_wr_data = ctl.clear ? '0 : dp_wr_data;

  gac_frame_mem #(
    .DEPTH (DEPTH)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (ctl.acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load on finish, drop on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin) begin
      res_r <= result;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_blue  = res_r.out_blue;
  assign out_bus.out_green = res_r.out_green;
  assign out_bus.out_red   = res_r.out_red;
  assign out_bus.out_alpha = res_r.out_alpha;
  assign out_bus.written   = res_r.written;
  assign out_bus.outside   = res_r.outside;

  // The datapath never writes the store while the clearing pass runs
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> !dp_wr_en)
    else $error("blend write during clearing pass");

  // An accepted item blocks the next one until its result is loaded
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("second item accepted while one is in flight");

  // A finished item always lands in the output register
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |=> out_valid_r)
    else $error("finished item not presented");

  // A written pixel is never reported as outside the frame
  a_written_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.written && res_r.outside))
    else $error("write reported outside the frame");

endmodule

// ===== dv/glyph_alpha_compositor_tb.sv =====
`timescale 1ns / 1ps

module glyph_alpha_compositor_tb;

  localparam int TIMEOUT_NS   = 4_000_000;
  localparam int DRAIN_CYCLES = 10;    // extra settle time after the last result is checked
  localparam int LONG_HOLD    = 300;   // receiver hold-off, long enough to back up the input
  localparam int OPAQUE       = gac_pkg::BYTE_MAX;
  localparam int MAX_W        = gac_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H        = gac_pkg::MAX_HEIGHT_DEF;
  // Index with no register behind it; a write there must change nothing
  localparam logic [gac_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

  typedef enum int {PACE_BURST, PACE_MIXED, PACE_SPARSE} pace_t;

  logic clk = 1'b0;
  logic rst_n;

  gac_item_if   in_if ();
  gac_result_if out_if ();
  gac_cfg_if    cfg_if ();

  glyph_alpha_compositor dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow of the frame store and the size registers, as the block should hold them
  logic [gac_pkg::PIX_W-1:0]       pixel_mirror [MAX_W*MAX_H] = '{default: '0};
  logic [gac_pkg::FRAME_DIM_W-1:0] frame_w = 9'd256;
  logic [gac_pkg::FRAME_DIM_W-1:0] frame_h = 9'd256;

  gac_pkg::item_t   pending_items[$];     // waiting for the driver
  gac_pkg::result_t expected_pixels[$];   // predicted, waiting for the monitor
  gac_pkg::item_t   offered_item;

  pace_t in_pace  = PACE_MIXED;
  pace_t out_pace = PACE_MIXED;
  int    in_wait, out_wait, hold_left;
  int    hold_requests = 0;
  int    holds_served;

  int items_queued   = 0;
  int beats_accepted = 0;
  int beats_checked  = 0;
  int error_count    = 0;
  int n_written = 0, n_skipped = 0, n_clipped = 0, n_reads = 0, reg_writes = 0;

  function automatic int pace_draw(pace_t p);
    case (p)
      PACE_BURST: return 0;
      PACE_MIXED: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 18);
      default:    return $urandom_range(0, 18);
    endcase
  endfunction

  // Apply one item to the shadow store and return the result beat it must produce
  function automatic gac_pkg::result_t blend_into_mirror(gac_pkg::item_t it);
    gac_pkg::result_t r;
    int               x, y, wc, hc, idx, a, cov, tr;
    int               ob, og, orr, oa;
    logic [31:0]      px;
    r   = '0;
    x   = $signed(it.pos_x);
    y   = $signed(it.pos_y);
    wc  = (int'(frame_w) > MAX_W) ? MAX_W : int'(frame_w);
    hc  = (int'(frame_h) > MAX_H) ? MAX_H : int'(frame_h);
    if (it.func == gac_pkg::FUNC_READ) n_reads++;
    if (x < 0 || y < 0 || x >= wc || y >= hc) begin
      // clipped: zero pixel, store untouched
      r.outside = 1'b1;
      n_clipped++;
      return r;
    end
    idx = y * MAX_W + x;
    px  = pixel_mirror[idx];
    if (it.func == gac_pkg::FUNC_BLEND) begin
      cov = int'(it.coverage);
      tr  = int'(it.transparency);
      a   = cov * (OPAQUE - tr) / OPAQUE;
      if (a != 0) begin
        ob  = int'(px[7:0]);
        og  = int'(px[15:8]);
        orr = int'(px[23:16]);
        oa  = int'(px[31:24]);
        px[7:0]   = 8'((int'(it.blue_level) * a + ob * (OPAQUE - a)) / OPAQUE);
        px[15:8]  = 8'((int'(it.green_level) * a + og * (OPAQUE - a)) / OPAQUE);
        px[23:16] = 8'((int'(it.red_level) * a + orr * (OPAQUE - a)) / OPAQUE);
        px[31:24] = 8'(a + oa * (OPAQUE - a) / OPAQUE);
        pixel_mirror[idx] = px;
        r.written = 1'b1;
        n_written++;
      end else begin
        n_skipped++;
      end
    end
    r.out_blue  = px[7:0];
    r.out_green = px[15:8];
    r.out_red   = px[23:16];
    r.out_alpha = px[31:24];
    return r;
  endfunction

  // Driver: present one beat at a time, hold it until taken, then idle for the drawn gap.
  // Predict at the accepting edge so the shadow store follows the block's order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_pixels.push_back(blend_into_mirror(offered_item));
        beats_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          offered_item = pending_items.pop_front();
          in_if.func         <= offered_item.func;
          in_if.pos_x        <= offered_item.pos_x;
          in_if.pos_y        <= offered_item.pos_y;
          in_if.coverage     <= offered_item.coverage;
          in_if.red_level    <= offered_item.red_level;
          in_if.green_level  <= offered_item.green_level;
          in_if.blue_level   <= offered_item.blue_level;
          in_if.transparency <= offered_item.transparency;
          in_if.valid        <= 1'b1;
          in_wait = pace_draw(in_pace);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, then stall at random.
  // A hold-off request from the stimulus blocks ready until the LONG_HOLD countdown runs out.
  always @(posedge clk) begin
    gac_pkg::result_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_wait     = 0;
      hold_left    = 0;
      holds_served = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.out_blue  = out_if.out_blue;
        got.out_green = out_if.out_green;
        got.out_red   = out_if.out_red;
        got.out_alpha = out_if.out_alpha;
        got.written   = out_if.written;
        got.outside   = out_if.outside;
        if (expected_pixels.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat b=%h g=%h r=%h a=%h w=%b o=%b", $realtime,
                   got.out_blue, got.out_green, got.out_red, got.out_alpha,
                   got.written, got.outside);
        end else begin
          want = expected_pixels.pop_front();
          beats_checked++;
          if (got.out_blue !== want.out_blue || got.out_green !== want.out_green ||
              got.out_red !== want.out_red || got.out_alpha !== want.out_alpha ||
              got.written !== want.written || got.outside !== want.outside) begin
            error_count++;
            $display("%0t: pixel mismatch, expected b=%h g=%h r=%h a=%h w=%b o=%b",
                     $realtime, want.out_blue, want.out_green, want.out_red,
                     want.out_alpha, want.written, want.outside);
            $display("%0t:   got b=%h g=%h r=%h a=%h w=%b o=%b",
                     $realtime, got.out_blue, got.out_green, got.out_red,
                     got.out_alpha, got.written, got.outside);
          end
        end
        out_wait = pace_draw(out_pace);
      end
      if (holds_served != hold_requests) begin
        hold_left    = LONG_HOLD;
        holds_served = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic func, input int x, input int y, input int cov,
                           input int red, input int green, input int blue, input int tr);
    gac_pkg::item_t it;
    it.func         = func;
    it.pos_x        = x[11:0];
    it.pos_y        = y[11:0];
    it.coverage     = cov[7:0];
    it.red_level    = red[7:0];
    it.green_level  = green[7:0];
    it.blue_level   = blue[7:0];
    it.transparency = tr[7:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Pick a coordinate: mostly a small hot area so pixels get blended again and again
  // (back-to-back read-modify-write), the rest on the clip edges, anywhere in the span or anywhere in 12 bits.
  function automatic int pick_coord(input int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom_range(0, ((span < 8) ? span : 8) - 1);
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       return -1;
        1:       return 0;
        2:       return span - 1;
        default: return span;
      endcase
    end
    if (sel == 7) return $urandom_range(0, span - 1);
    return $signed(12'($urandom_range(0, 4095)));
  endfunction

  task automatic push_random_item();
    int  wc, hc, cov, tr;
    logic func;
    wc   = (int'(frame_w) > MAX_W) ? MAX_W : int'(frame_w);
    hc   = (int'(frame_h) > MAX_H) ? MAX_H : int'(frame_h);
    func = ($urandom_range(0, 4) == 0) ? gac_pkg::FUNC_READ : gac_pkg::FUNC_BLEND;
    case ($urandom_range(0, 7))
      0:       cov = 0;
      1:       cov = OPAQUE;
      default: cov = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 7))
      0, 1:    tr = 0;
      2:       tr = OPAQUE;
      default: tr = $urandom_range(0, 255);
    endcase
    push_item(func, pick_coord(wc), pick_coord(hc), cov, $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), tr);
  endtask

  // Register write; only called once the block has drained
  task automatic write_reg(input logic [gac_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[gac_pkg::FRAME_DIM_W-1:0];
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      gac_pkg::REG_FRAME_WIDTH:  frame_w = value[gac_pkg::FRAME_DIM_W-1:0];
      gac_pkg::REG_FRAME_HEIGHT: frame_h = value[gac_pkg::FRAME_DIM_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Hold until every queued item was taken and answered, then let the pipe settle
  task automatic wait_drained();
    while (beats_accepted != items_queued || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input int w, input int h, input int count,
                                  input pace_t ipace, input pace_t opace, input bit hold_off);
    write_reg(gac_pkg::REG_FRAME_WIDTH, w);
    write_reg(gac_pkg::REG_FRAME_HEIGHT, h);
    in_pace  = ipace;
    out_pace = opace;
    if (hold_off) hold_requests++;
    repeat (count) push_random_item();
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = gac_pkg::FUNC_BLEND;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    in_if.coverage     = '0;
    in_if.red_level    = '0;
    in_if.green_level  = '0;
    in_if.blue_level   = '0;
    in_if.transparency = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = gac_pkg::REG_FRAME_WIDTH;
    cfg_if.data        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed at the reset geometry; beats wait out the clearing pass on in_ready
    push_item(gac_pkg::FUNC_BLEND, 0, 0, 255, 255, 0, 128, 0);     // fully opaque over empty
    push_item(gac_pkg::FUNC_READ, 0, 0, 17, 200, 100, 50, 9);      // colour fields ignored
    push_item(gac_pkg::FUNC_BLEND, 0, 0, 128, 0, 255, 0, 0);       // partial over opaque
    push_item(gac_pkg::FUNC_BLEND, 0, 0, 255, 1, 2, 3, 255);       // fully transparent: no write
    push_item(gac_pkg::FUNC_BLEND, 1, 0, 0, 255, 255, 255, 0);     // zero coverage: no write
    push_item(gac_pkg::FUNC_BLEND, 255, 255, 200, 10, 20, 30, 55); // far corner, inside
    push_item(gac_pkg::FUNC_BLEND, 256, 10, 255, 9, 9, 9, 0);      // one past the right edge
    push_item(gac_pkg::FUNC_BLEND, 10, 256, 255, 9, 9, 9, 0);      // one past the bottom edge
    push_item(gac_pkg::FUNC_BLEND, -1, 0, 255, 9, 9, 9, 0);
    push_item(gac_pkg::FUNC_BLEND, 0, -1, 255, 9, 9, 9, 0);
    push_item(gac_pkg::FUNC_BLEND, -2048, 2047, 255, 9, 9, 9, 0);
    push_item(gac_pkg::FUNC_BLEND, 2047, -2048, 255, 9, 9, 9, 0);
    push_item(gac_pkg::FUNC_READ, 255, 255, 0, 0, 0, 0, 0);
    push_item(gac_pkg::FUNC_READ, -1, -1, 255, 255, 255, 255, 255); // read outside
    push_item(gac_pkg::FUNC_READ, 3, 3, 0, 0, 0, 0, 0);             // untouched pixel reads zero
    push_item(gac_pkg::FUNC_BLEND, 7, 7, 1, 255, 255, 255, 0);      // smallest nonzero alpha
    push_item(gac_pkg::FUNC_BLEND, 7, 7, 255, 0, 0, 0, 254);        // same alpha via transparency
    push_item(gac_pkg::FUNC_BLEND, 7, 7, 254, 128, 64, 32, 1);
    push_item(gac_pkg::FUNC_BLEND, 5, 5, 255, 255, 255, 255, 0);    // back-to-back on one pixel
    push_item(gac_pkg::FUNC_BLEND, 5, 5, 100, 0, 0, 0, 0);
    push_item(gac_pkg::FUNC_BLEND, 5, 5, 100, 0, 0, 0, 0);
    push_item(gac_pkg::FUNC_READ, 5, 5, 0, 0, 0, 0, 0);
    wait_drained();

    // Zero width: every position clipped
    write_reg(gac_pkg::REG_FRAME_WIDTH, 0);
    push_item(gac_pkg::FUNC_BLEND, 0, 0, 255, 255, 255, 255, 0);
    push_item(gac_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Single-pixel frame
    write_reg(gac_pkg::REG_FRAME_WIDTH, 1);
    write_reg(gac_pkg::REG_FRAME_HEIGHT, 1);
    push_item(gac_pkg::FUNC_BLEND, 0, 0, 90, 40, 50, 60, 30);
    push_item(gac_pkg::FUNC_BLEND, 1, 0, 255, 40, 50, 60, 0);
    push_item(gac_pkg::FUNC_BLEND, 0, 1, 255, 40, 50, 60, 0);
    push_item(gac_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Oversized registers saturate to the store geometry; the spare index changes nothing
    write_reg(gac_pkg::REG_FRAME_WIDTH, 511);
    write_reg(gac_pkg::REG_FRAME_HEIGHT, 511);
    write_reg(REG_SPARE, 3);
    push_item(gac_pkg::FUNC_BLEND, 255, 255, 255, 1, 1, 1, 0);
    push_item(gac_pkg::FUNC_BLEND, 256, 0, 255, 1, 1, 1, 0);
    push_item(gac_pkg::FUNC_BLEND, 0, 256, 255, 1, 1, 1, 0);
    push_item(gac_pkg::FUNC_READ, 255, 255, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases across geometries and pacing; the second one backs the block up
    run_random_phase(256, 256, 90, PACE_MIXED, PACE_MIXED, 1'b0);
    run_random_phase(13, 9, 90, PACE_BURST, PACE_MIXED, 1'b1);
    run_random_phase(1, 256, 70, PACE_SPARSE, PACE_BURST, 1'b0);
    run_random_phase(511, 300, 90, PACE_MIXED, PACE_SPARSE, 1'b0);
    run_random_phase(64, 3, 90, PACE_BURST, PACE_BURST, 1'b0);

    $display("checked %0d result beats: %0d blends written, %0d zero-alpha skips,",
             beats_checked, n_written, n_skipped);
    $display("%0d clipped positions, %0d reads, %0d register writes over 9 geometries",
             n_clipped, n_reads, reg_writes);
    if (error_count == 0) begin
      $display("glyph_alpha_compositor_tb: clean");
    end else begin
      $display("glyph_alpha_compositor_tb: errors");
    end
    $finish;
  end

  // Watchdog: clearing pass plus every beat at its slowest, several times over
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d of %0d items taken, %0d results pending", $realtime,
             beats_accepted, items_queued, expected_pixels.size());
    $display("glyph_alpha_compositor_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gac_pkg.sv
rtl/gac_ifs.sv
rtl/gac_frame_mem.sv
rtl/gac_ctrl.sv
rtl/gac_datapath.sv
rtl/glyph_alpha_compositor.sv
dv/glyph_alpha_compositor_tb.sv
